>>> sv/sndgen_pkg.sv
// Shared types, register map and tables for the programmable sound generator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package sndgen_pkg;

  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_READ  = 2'd2
  } func_e;

  localparam int unsigned NumRegs   = 16;
  localparam int unsigned NumVoices = 3;

  localparam logic [3:0] RegNoisePer = 4'd6;
  localparam logic [3:0] RegMixer    = 4'd7;
  localparam logic [3:0] RegAmpA     = 4'd8;
  localparam logic [3:0] RegEnvLo    = 4'd11;
  localparam logic [3:0] RegEnvHi    = 4'd12;
  localparam logic [3:0] RegShape    = 4'd13;

  localparam logic [7:0] MixerReset = 8'h3F;

  localparam int unsigned SampleW = 15;
  localparam int unsigned SumW    = 17;
  // floor(x/3) == (x * DivThreeMul) >> DivThreeShift for x < 2**17
  localparam logic [15:0] DivThreeMul   = 16'd43691;
  localparam int unsigned DivThreeShift = 17;

  typedef struct packed {
    logic [5:0]                          mixer;
    logic [NumVoices-1:0][4:0]           amp;
    logic [NumVoices-1:0]                tone_lvl;
    logic                                noise_lvl;
    logic [3:0]                          env_pos;
  } mix_state_t;

  function automatic logic [SampleW-1:0] vol_lookup(input logic [3:0] amp);
    logic [SampleW-1:0] v;
    unique case (amp)
      4'd0:  v = 15'd0;
      4'd1:  v = 15'd218;
      4'd2:  v = 15'd311;
      4'd3:  v = 15'd442;
      4'd4:  v = 15'd628;
      4'd5:  v = 15'd891;
      4'd6:  v = 15'd1264;
      4'd7:  v = 15'd1793;
      4'd8:  v = 15'd2545;
      4'd9:  v = 15'd3612;
      4'd10: v = 15'd5126;
      4'd11: v = 15'd7274;
      4'd12: v = 15'd10323;
      4'd13: v = 15'd14650;
      4'd14: v = 15'd20791;
      default: v = 15'd29505;
    endcase
    return v;
  endfunction

endpackage

>>> sv/sndgen_core.sv
// Register file, tone/noise/envelope dividers and envelope sequencer.
// Depends on sndgen_pkg.
`timescale 1ns / 1ps

module sndgen_core (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  sndgen_pkg::func_e       func_i,
  input  logic [3:0]              reg_index_i,
  input  logic [7:0]              write_value_i,
  output logic [7:0]              read_data_o,
  output sndgen_pkg::mix_state_t  mix_state_o
);
  import sndgen_pkg::*;

  logic [NumRegs-1:0][7:0]    regs_q;
  logic [NumVoices-1:0][11:0] tone_cnt_q, tone_cnt_d;
  logic [NumVoices-1:0]       tone_lvl_q, tone_lvl_d;
  logic [5:0]                 noise_cnt_q, noise_cnt_d;
  logic [16:0]                lfsr_q, lfsr_d;
  logic                       noise_lvl_q, noise_lvl_d;
  logic [19:0]                env_cnt_q, env_cnt_d;
  logic [3:0]                 env_pos_q, env_pos_d;
  logic                       env_hold_q, env_hold_d;
  logic                       env_rise_q, env_rise_d;
  logic [7:0]                 rd_q;

  for (genvar v = 0; v < NumVoices; v++) begin : g_tone
    logic [11:0] per, inc;
    assign per = ({regs_q[2*v+1][3:0], regs_q[2*v]} == 12'd0) ? 12'd1
               : {regs_q[2*v+1][3:0], regs_q[2*v]};
    assign inc = tone_cnt_q[v] + 12'd1;
    assign tone_cnt_d[v] = (inc >= per) ? 12'd0 : inc;
    assign tone_lvl_d[v] = (inc >= per) ? ~tone_lvl_q[v] : tone_lvl_q[v];
  end

  logic [4:0] noise_per;
  logic [5:0] noise_inc;
  logic       noise_exp;
  assign noise_per = (regs_q[RegNoisePer][4:0] == 5'd0) ? 5'd1 : regs_q[RegNoisePer][4:0];
  assign noise_inc = noise_cnt_q + 6'd1;
  assign noise_exp = noise_inc >= {noise_per, 1'b0};
  assign noise_cnt_d = noise_exp ? 6'd0 : noise_inc;
  assign lfsr_d      = noise_exp ? {lfsr_q[0] ^ lfsr_q[3], lfsr_q[16:1]} : lfsr_q;
  assign noise_lvl_d = noise_exp ? lfsr_q[1] : noise_lvl_q;

  logic [15:0] env_per;
  logic [19:0] env_inc;
  logic        env_exp, at_end;
  logic        sh_hold, sh_alt, sh_cont;
  assign env_per = ({regs_q[RegEnvHi], regs_q[RegEnvLo]} == 16'd0) ? 16'd1
                 : {regs_q[RegEnvHi], regs_q[RegEnvLo]};
  assign env_inc = env_cnt_q + 20'd1;
  assign env_exp = env_inc >= {env_per, 4'b0000};
  assign env_cnt_d = env_exp ? 20'd0 : env_inc;
  assign sh_hold = regs_q[RegShape][0];
  assign sh_alt  = regs_q[RegShape][1];
  assign sh_cont = regs_q[RegShape][3];
  assign at_end  = env_rise_q ? (env_pos_q == 4'd15) : (env_pos_q == 4'd0);

  always_comb begin
    env_pos_d  = env_pos_q;
    env_hold_d = env_hold_q;
    env_rise_d = env_rise_q;
    if (env_exp && !env_hold_q) begin
      if (!at_end) begin
        env_pos_d = env_rise_q ? env_pos_q + 4'd1 : env_pos_q - 4'd1;
      end else if (!sh_cont) begin
        env_pos_d  = 4'd0;
        env_hold_d = 1'b1;
      end else if (sh_hold) begin
        if (sh_alt) env_pos_d = env_rise_q ? 4'd0 : 4'd15;
        env_hold_d = 1'b1;
      end else if (sh_alt) begin
        env_rise_d = ~env_rise_q;
      end else begin
        env_pos_d = env_rise_q ? 4'd0 : 4'd15;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumRegs; i++) regs_q[i] <= 8'h00;
      regs_q[RegMixer] <= MixerReset;
      tone_cnt_q  <= '0;
      tone_lvl_q  <= '0;
      noise_cnt_q <= '0;
      lfsr_q      <= 17'd1;
      noise_lvl_q <= 1'b0;
      env_cnt_q   <= '0;
      env_pos_q   <= 4'd15;
      env_hold_q  <= 1'b0;
      env_rise_q  <= 1'b0;
      rd_q        <= '0;
    end else if (en_i) begin
      unique case (func_i)
        FUNC_TICK: begin
          rd_q        <= 8'h00;
          tone_cnt_q  <= tone_cnt_d;
          tone_lvl_q  <= tone_lvl_d;
          noise_cnt_q <= noise_cnt_d;
          lfsr_q      <= lfsr_d;
          noise_lvl_q <= noise_lvl_d;
          env_cnt_q   <= env_cnt_d;
          env_pos_q   <= env_pos_d;
          env_hold_q  <= env_hold_d;
          env_rise_q  <= env_rise_d;
        end
        FUNC_WRITE: begin
          rd_q <= 8'h00;
          regs_q[reg_index_i] <= write_value_i;
          if (reg_index_i == RegShape) begin
            env_hold_q <= 1'b0;
            env_cnt_q  <= '0;
            env_rise_q <= write_value_i[2];
            env_pos_q  <= write_value_i[2] ? 4'd0 : 4'd15;
          end
        end
        FUNC_READ: rd_q <= regs_q[reg_index_i];
        default: rd_q <= 8'h00;
      endcase
    end
  end

  assign read_data_o = rd_q;

  always_comb begin
    mix_state_o.mixer     = regs_q[RegMixer][5:0];
    for (int v = 0; v < NumVoices; v++) begin
      mix_state_o.amp[v] = regs_q[RegAmpA + 4'(v)][4:0];
    end
    mix_state_o.tone_lvl  = tone_lvl_q;
    mix_state_o.noise_lvl = noise_lvl_q;
    mix_state_o.env_pos   = env_pos_q;
  end

endmodule

>>> sv/sndgen_mix.sv
// Mixer: voice gating, log volume lookup and sum, then divide by three.
// Depends on sndgen_pkg.
`timescale 1ns / 1ps

module sndgen_mix (
  input  logic                              clk_i,
  input  logic                              sum_en_i,
  input  logic                              div_en_i,
  input  sndgen_pkg::mix_state_t            mix_state_i,
  input  logic [7:0]                        read_data_i,
  output logic [sndgen_pkg::SampleW-1:0]    sample_o,
  output logic [7:0]                        read_data_o
);
  import sndgen_pkg::*;

  logic [NumVoices-1:0][SampleW-1:0] level;
  logic [SumW-1:0]                   sum_d, sum_q;
  logic [7:0]                        rd2_q, rd3_q;
  logic [SumW+15:0]                  prod;
  logic [SampleW-1:0]                sample_q;

  for (genvar v = 0; v < NumVoices; v++) begin : g_voice
    logic on;
    logic [3:0] amp;
    assign on  = (mix_state_i.mixer[v] | mix_state_i.tone_lvl[v]) &
                 (mix_state_i.mixer[v+3] | mix_state_i.noise_lvl);
    assign amp = mix_state_i.amp[v][4] ? mix_state_i.env_pos : mix_state_i.amp[v][3:0];
    assign level[v] = on ? vol_lookup(amp) : '0;
  end

  assign sum_d = SumW'(level[0]) + SumW'(level[1]) + SumW'(level[2]);
  assign prod  = sum_q * DivThreeMul;

  always_ff @(posedge clk_i) begin
    if (sum_en_i) begin
      sum_q <= sum_d;
      rd2_q <= read_data_i;
    end
    if (div_en_i) begin
      sample_q <= prod[DivThreeShift +: SampleW];
      rd3_q    <= rd2_q;
    end
  end

  assign sample_o    = sample_q;
  assign read_data_o = rd3_q;

endmodule

>>> sv/programmable_sound_generator.sv
// Top level of the programmable sound generator: stream ports and pipeline control.
// Depends on sndgen_pkg, sndgen_core and sndgen_mix.
`timescale 1ns / 1ps

// Three square-wave voices, a 17-bit LFSR noise source and an envelope, set up
// through sixteen 8-bit registers. Each input beat is one operation chosen by
// tuser: a tick, a register write or a register read; each produces exactly one
// output beat carrying the mixed level after the operation and the read data
// (zero unless a read). One beat is accepted per clock unless a stalled output has
// filled the stages; a result passes through the input register, state update,
// volume sum and divide by three via a 17x16 reciprocal multiply before it is
// offered on the output. Each stage advances independently, so a stalled output
// only holds back stages that are full.

module programmable_sound_generator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [3:0] reg_index, [11:4] write_value, [15:12] zero
  input  logic [1:0]  s_axis_tuser,   // [1:0] func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // [14:0] sample, [22:15] read_data, [23] zero
);
  import sndgen_pkg::*;

  logic       v0_q, v1_q, v2_q, v3_q;
  logic       rdy1, rdy2, rdy3;
  logic       s_fire, fire0, fire1, fire2;
  func_e      func_q;
  logic [3:0] idx_q;
  logic [7:0] val_q;

  mix_state_t         mix_state;
  logic [7:0]         core_rd, mix_rd;
  logic [SampleW-1:0] sample;

  assign rdy3   = !v3_q || m_axis_tready;
  assign fire2  = v2_q && rdy3;
  assign rdy2   = !v2_q || rdy3;
  assign fire1  = v1_q && rdy2;
  assign rdy1   = !v1_q || rdy2;
  assign fire0  = v0_q && rdy1;
  assign s_axis_tready = !v0_q || rdy1;
  assign s_fire = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (s_fire) v0_q <= 1'b1;
      else if (fire0) v0_q <= 1'b0;
      if (fire0) v1_q <= 1'b1;
      else if (fire1) v1_q <= 1'b0;
      if (fire1) v2_q <= 1'b1;
      else if (fire2) v2_q <= 1'b0;
      if (fire2) v3_q <= 1'b1;
      else if (m_axis_tready) v3_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      func_q <= func_e'(s_axis_tuser);
      idx_q  <= s_axis_tdata[3:0];
      val_q  <= s_axis_tdata[11:4];
    end
  end

  sndgen_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (fire0),
    .func_i        (func_q),
    .reg_index_i   (idx_q),
    .write_value_i (val_q),
    .read_data_o   (core_rd),
    .mix_state_o   (mix_state)
  );

  sndgen_mix u_mix (
    .clk_i       (clk_i),
    .sum_en_i    (fire1),
    .div_en_i    (fire2),
    .mix_state_i (mix_state),
    .read_data_i (core_rd),
    .sample_o    (sample),
    .read_data_o (mix_rd)
  );

  assign m_axis_tvalid = v3_q;
  assign m_axis_tdata  = {1'b0, mix_rd, sample};

endmodule

>>> sim/tb.sv
// Testbench for programmable_sound_generator: register writes, reads and ticks
// with random idling on both streams, checked beat by beat against a predictor.
// Depends on sndgen_pkg and the programmable_sound_generator RTL.
`timescale 1ns / 1ps

module tb;
  import sndgen_pkg::*;

  localparam logic [1:0] FuncUnused = 2'd3;

  localparam logic [3:0] RegToneLoA = 4'd0;
  localparam logic [3:0] RegToneHiA = 4'd1;
  localparam logic [3:0] RegAmpB    = 4'd9;
  localparam logic [3:0] RegAmpC    = 4'd10;
  localparam logic [3:0] RegSpareLo = 4'd14;
  localparam logic [3:0] RegSpareHi = 4'd15;

  localparam int ShapeHold = 0;
  localparam int ShapeAlt  = 1;
  localparam int ShapeAtk  = 2;
  localparam int ShapeCont = 3;
  localparam int AmpEnvBit = 4;

  localparam int RandomOps  = 1400;
  localparam int StallLimit = 400;
  localparam int MaxReports = 200;

  typedef struct packed {
    logic [14:0] sample;
    logic [7:0]  read_data;
  } mix_result_t;

  class voice_mix_scoreboard;
    logic [7:0]  regs [16];
    logic [11:0] tone_cnt [3];
    logic        tone_lvl [3];
    logic [5:0]  noise_cnt;
    logic [16:0] lfsr;
    logic        noise_lvl;
    logic [19:0] env_cnt;
    logic [3:0]  env_pos;
    logic        env_hold;
    logic        env_up;
    int unsigned level_lut [16];
    mix_result_t expected_mix [$];
    int          errors;

    function new();
      level_lut = '{0, 218, 311, 442, 628, 891, 1264, 1793,
                    2545, 3612, 5126, 7274, 10323, 14650, 20791, 29505};
      foreach (regs[i]) regs[i] = 8'h00;
      regs[RegMixer] = MixerReset;
      foreach (tone_cnt[i]) begin
        tone_cnt[i] = 12'd0;
        tone_lvl[i] = 1'b0;
      end
      noise_cnt = 6'd0;
      lfsr      = 17'd1;
      noise_lvl = 1'b0;
      env_cnt   = 20'd0;
      env_pos   = 4'd15;
      env_hold  = 1'b0;
      env_up    = 1'b0;
      errors    = 0;
    endfunction

    function int pending();
      return expected_mix.size();
    endfunction

    function void step_envelope();
      logic at_end;
      if (env_hold) return;
      at_end = env_up ? (env_pos == 4'd15) : (env_pos == 4'd0);
      if (!at_end) begin
        env_pos = env_up ? env_pos + 4'd1 : env_pos - 4'd1;
      end else if (!regs[RegShape][ShapeCont]) begin
        env_pos  = 4'd0;
        env_hold = 1'b1;
      end else if (regs[RegShape][ShapeHold]) begin
        if (regs[RegShape][ShapeAlt]) env_pos = env_up ? 4'd0 : 4'd15;
        env_hold = 1'b1;
      end else if (regs[RegShape][ShapeAlt]) begin
        env_up = !env_up;
      end else begin
        env_pos = env_up ? 4'd0 : 4'd15;
      end
    endfunction

    function void advance_tick();
      logic [11:0] per;
      logic [4:0]  np;
      logic [15:0] ep;
      logic        fb;
      int          v;
      for (v = 0; v < 3; v++) begin
        per = {regs[2*v+1][3:0], regs[2*v]};
        if (per == 12'd0) per = 12'd1;
        tone_cnt[v] = tone_cnt[v] + 12'd1;
        if (tone_cnt[v] >= per) begin
          tone_cnt[v] = 12'd0;
          tone_lvl[v] = !tone_lvl[v];
        end
      end
      np = regs[RegNoisePer][4:0];
      if (np == 5'd0) np = 5'd1;
      noise_cnt = noise_cnt + 6'd1;
      if (noise_cnt >= {np, 1'b0}) begin
        noise_cnt = 6'd0;
        fb        = lfsr[0] ^ lfsr[3];
        lfsr      = {fb, lfsr[16:1]};
        noise_lvl = lfsr[0];
      end
      ep = {regs[RegEnvHi], regs[RegEnvLo]};
      if (ep == 16'd0) ep = 16'd1;
      env_cnt = env_cnt + 20'd1;
      if (env_cnt >= {ep, 4'h0}) begin
        env_cnt = 20'd0;
        step_envelope();
      end
    endfunction

    function logic [14:0] mixed_level();
      int unsigned sum;
      logic        on;
      logic [7:0]  a;
      logic [3:0]  amp;
      int          v;
      sum = 0;
      for (v = 0; v < 3; v++) begin
        on = 1'b1;
        if (!regs[RegMixer][v] && !tone_lvl[v]) on = 1'b0;
        if (!regs[RegMixer][v+3] && !noise_lvl) on = 1'b0;
        if (on) begin
          a   = regs[RegAmpA + v];
          amp = a[AmpEnvBit] ? env_pos : a[3:0];
          sum += level_lut[amp];
        end
      end
      return 15'(sum / 3);
    endfunction

    function void note_op(logic [1:0] op, logic [3:0] idx, logic [7:0] val);
      mix_result_t r;
      r.read_data = 8'h00;
      if (op == FUNC_TICK) begin
        advance_tick();
      end else if (op == FUNC_WRITE) begin
        regs[idx] = val;
        if (idx == RegShape) begin
          env_hold = 1'b0;
          env_cnt  = 20'd0;
          env_up   = val[ShapeAtk];
          env_pos  = env_up ? 4'd0 : 4'd15;
        end
      end else if (op == FUNC_READ) begin
        r.read_data = regs[idx];
      end
      r.sample = mixed_level();
      expected_mix.push_back(r);
    endfunction

    function void check_beat(logic [14:0] sample, logic [7:0] read_data);
      mix_result_t r;
      if (expected_mix.size() == 0) begin
        if (errors < MaxReports)
          $display("%0t: unexpected beat, sample %0d read_data 0x%02h",
                   $time, sample, read_data);
        errors++;
        return;
      end
      r = expected_mix.pop_front();
      if (sample !== r.sample) begin
        if (errors < MaxReports)
          $display("%0t: sample expected %0d, actual %0d", $time, r.sample, sample);
        errors++;
      end
      if (read_data !== r.read_data) begin
        if (errors < MaxReports)
          $display("%0t: read_data expected 0x%02h, actual 0x%02h",
                   $time, r.read_data, read_data);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;   // [3:0] reg_index, [11:4] write_value, [15:12] zero
  logic [1:0]  s_axis_tuser;   // [1:0] func
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;   // [14:0] sample, [22:15] read_data, [23] zero

  voice_mix_scoreboard sb;
  bit gapless;
  int ops_sent;
  int idle_cycles;

  programmable_sound_generator uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  task automatic send_op(input logic [1:0] op, input logic [3:0] idx,
                         input logic [7:0] val);
    int gap;
    gap = gapless ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {4'h0, val, idx};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_op(op, idx, val);
    ops_sent++;
  endtask

  // Mostly short periods so the tones, noise and envelope move within a burst.
  function automatic logic [7:0] pick_value(input logic [3:0] idx);
    logic [7:0] v;
    v = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 4) == 0) return v;
    if (idx < RegNoisePer)
      v = idx[0] ? 8'h00 : 8'($urandom_range(0, 12));
    else if (idx == RegMixer)
      v = 8'($urandom_range(0, 63));
    else if (idx >= RegAmpA && idx <= RegAmpC)
      v = 8'($urandom_range(0, 31));
    else if (idx == RegEnvLo)
      v = 8'($urandom_range(0, 2));
    else if (idx == RegEnvHi)
      v = 8'h00;
    else if (idx == RegShape)
      v = 8'($urandom_range(0, 15));
    return v;
  endfunction

  initial begin
    int         n_ticks;
    int         n_setup;
    logic [3:0] idx;
    sb = new();
    gapless = 1'b0;
    ops_sent = 0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= 16'h0000;
    s_axis_tuser  <= FUNC_TICK;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_op(FUNC_READ,  RegMixer,    8'h00);
    send_op(FUNC_TICK,  RegToneLoA,  8'h00);
    send_op(FUNC_WRITE, RegToneLoA,  8'hFF);
    send_op(FUNC_WRITE, RegToneHiA,  8'hFF);
    send_op(FUNC_WRITE, RegAmpA,     8'h1F);
    send_op(FUNC_WRITE, RegAmpB,     8'h0F);
    send_op(FUNC_WRITE, RegMixer,    8'h00);
    send_op(FUNC_WRITE, RegNoisePer, 8'h1F);
    send_op(FUNC_WRITE, RegShape,    8'h0F);
    send_op(FUNC_TICK,  RegSpareHi,  8'hFF);
    send_op(FUNC_READ,  RegToneHiA,  8'h00);
    send_op(FUNC_WRITE, RegSpareLo,  8'hAA);
    send_op(FUNC_WRITE, RegSpareHi,  8'h55);
    send_op(FUNC_READ,  RegSpareHi,  8'h00);
    send_op(FuncUnused, RegSpareHi,  8'hFF);
    send_op(FUNC_READ,  RegShape,    8'h00);
    // zero periods count as one
    send_op(FUNC_WRITE, RegToneLoA,  8'h00);
    send_op(FUNC_WRITE, RegToneHiA,  8'h00);
    send_op(FUNC_WRITE, RegAmpC,     8'h1F);
    repeat (4) send_op(FUNC_TICK, RegToneLoA, 8'h00);
    send_op(FUNC_WRITE, RegShape,    8'h00);
    send_op(FUNC_TICK,  RegToneLoA,  8'h00);

    while (ops_sent < RandomOps) begin
      gapless = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 4))
          send_op(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                  8'($urandom_range(0, 255)));
      end else begin
        n_setup = $urandom_range(1, 4);
        repeat (n_setup) begin
          idx = 4'($urandom_range(0, 15));
          send_op(FUNC_WRITE, idx, pick_value(idx));
        end
        if ($urandom_range(0, 2) == 0) send_op(FUNC_WRITE, RegShape, pick_value(RegShape));
        n_ticks = $urandom_range(10, 80);
        repeat (n_ticks) begin
          if ($urandom_range(0, 11) == 0)
            send_op(FUNC_READ, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
          else
            send_op(FUNC_TICK, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
        end
      end
    end
    s_axis_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    int stall;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = gapless ? 0 : $urandom_range(0, 8);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      sb.check_beat(m_axis_tdata[14:0], m_axis_tdata[22:15]);
    end
  end

  initial idle_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("%0t: no beat accepted for %0d cycles", $time, StallLimit);
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
